[design/i2cscr_pkg.sv]
// shared constants and lookup functions for the shunt current reader
package i2cscr_pkg;

    localparam int unsigned PORT_COUNT = 8;

    localparam int unsigned ADDR_W     = 7;
    localparam int unsigned PORT_W     = 4;
    localparam int unsigned CHAN_W     = 3;
    localparam int unsigned CUR_W      = 14;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MON_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_C = 2'd2;

    // monitor selectors
    localparam logic [1:0] MON_A = 2'd0;
    localparam logic [1:0] MON_B = 2'd1;
    localparam logic [1:0] MON_C = 2'd2;

    // shunt register pointers inside a monitor
    localparam logic [7:0] SHUNT_REG_1 = 8'h05;
    localparam logic [7:0] SHUNT_REG_2 = 8'h03;
    localparam logic [7:0] SHUNT_REG_3 = 8'h01;

    // ceil(2^18 / 5): exact divide by five for dividends below 2^18
    localparam logic [15:0] RECIP_5   = 16'd52429;
    localparam int unsigned RECIP_SHR = 18;

    function automatic logic [7:0] shunt_reg_of(input logic [CHAN_W-1:0] chan);
        logic [7:0] r;
        case (chan)
            3'd0, 3'd3, 3'd6: r = SHUNT_REG_1;
            3'd1, 3'd4:       r = SHUNT_REG_2;
            default:          r = SHUNT_REG_3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] monitor_of(input logic [CHAN_W-1:0] chan);
        logic [1:0] m;
        case (chan)
            3'd0, 3'd1, 3'd2: m = MON_A;
            3'd3, 3'd4, 3'd5: m = MON_B;
            default:          m = MON_C;
        endcase
        return m;
    endfunction

endpackage

[design/i2c_shunt_current_reader_top.sv]
// top level: bus master sequencer that reads one port's shunt word and scales it to milliamps
//
// channel   | direction | beat contents (lowest bit first)
// ----------+-----------+----------------------------------------------------------------
// s_axis    | in        | start_request[0], port[4:1], sda_sample[5], zero pad to 8
// m_axis    | out       | scl_drive_low[0], sda_drive_low[1], busy_res[2], done_res[3],
//           |           | ok[4], current_ma[18:5], zero pad to 24
// cfg       | in        | i_cfg_wen, i_cfg_index (0 monitor a, 1 b, 2 c), i_cfg_data 7 bits
//
// every input beat is one bus-delay tick and yields exactly one output beat
// one beat per clock: the whole tick update sits between the sequencer
// registers and the output register, limited by the 17x16 scaling multiply
// output register frees as it is read, so input stalls only while a result
// is held by m_axis_tready low
// synchronous active-low reset: sequencer idle, lines released, addresses 64/65/66
module i2c_shunt_current_reader_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_wen,
    input  logic [i2cscr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cscr_pkg::ADDR_W-1:0]       i_cfg_data,
    // tick input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_request[0], port[4:1], sda_sample[5], pad[7:6]
    input  logic [i2cscr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tick result
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // scl_drive_low[0], sda_drive_low[1], busy_res[2], done_res[3], ok[4],
    // current_ma[18:5], pad[23:19]
    output logic [i2cscr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // sequencer state codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FREE  = 4'd1;  // both lines released before start
    localparam logic [3:0] ST_SLOW  = 4'd2;  // start: sda low with scl high
    localparam logic [3:0] ST_WLOW  = 4'd3;  // write bit, scl low
    localparam logic [3:0] ST_WHIGH = 4'd4;  // write bit, scl high
    localparam logic [3:0] ST_ALOW  = 4'd5;  // ack slot, scl low
    localparam logic [3:0] ST_AHIGH = 4'd6;  // ack slot, scl high
    localparam logic [3:0] ST_RSLOW = 4'd7;  // repeated start prelude
    localparam logic [3:0] ST_RLOW  = 4'd8;  // read bit, scl low
    localparam logic [3:0] ST_RHIGH = 4'd9;  // read bit, scl high
    localparam logic [3:0] ST_MLOW  = 4'd10; // master ack/nack, scl low
    localparam logic [3:0] ST_MHIGH = 4'd11; // master ack/nack, scl high
    localparam logic [3:0] ST_PA    = 4'd12; // stop: both low
    localparam logic [3:0] ST_PB    = 4'd13; // stop: scl released

    // byte stage codes
    localparam logic [1:0] BYT_ADDR_W = 2'd0;
    localparam logic [1:0] BYT_REG    = 2'd1;
    localparam logic [1:0] BYT_ADDR_R = 2'd2;
    localparam logic [1:0] BYT_DATA   = 2'd3;

    localparam int unsigned MAG_W  = i2cscr_pkg::WORD_W + 1;
    localparam int unsigned PROD_W = MAG_W + i2cscr_pkg::WORD_W;

    // configuration
    logic [i2cscr_pkg::ADDR_W-1:0] r_mon_a_addr, r_mon_b_addr, r_mon_c_addr;

    // sequencer state
    logic [3:0]                           r_st,        n_st;
    logic [1:0]                           r_byt,       n_byt;
    logic [3:0]                           r_bit_index, n_bit_index;
    logic [7:0]                           r_shift_byte, n_shift_byte;
    logic [i2cscr_pkg::WORD_W-1:0]        r_read_word, n_read_word;
    logic [i2cscr_pkg::CHAN_W-1:0]        r_chosen_port, n_chosen_port;

    // output register
    logic                                 r_out_valid;
    logic [i2cscr_pkg::OUT_TDATA_W-1:0]   r_out_data, n_out_data;

    // input fields
    logic                                 in_req;
    logic [i2cscr_pkg::PORT_W-1:0]        in_port;
    logic                                 in_sda;
    logic                                 in_accept;

    // per-tick result pieces
    logic                                 done, ok;
    logic [i2cscr_pkg::CUR_W-1:0]         cur_ma;
    logic                                 scl_low, sda_low;
    logic                                 tx_bit;
    logic [i2cscr_pkg::ADDR_W-1:0]        dev_addr;
    logic [MAG_W-1:0]                     mag2;
    logic [PROD_W-1:0]                    prod;

    assign in_req  = s_axis_tdata[0];
    assign in_port = s_axis_tdata[4:1];
    assign in_sda  = s_axis_tdata[5];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // device address for the latched port
    always_comb begin
        case (i2cscr_pkg::monitor_of(r_chosen_port))
            i2cscr_pkg::MON_A: dev_addr = r_mon_a_addr;
            i2cscr_pkg::MON_B: dev_addr = r_mon_b_addr;
            default:           dev_addr = r_mon_c_addr;
        endcase
    end

    // |word| * 2 / 5 via reciprocal multiply; most negative word gives 65536 / 5
    always_comb begin
        if (r_read_word[i2cscr_pkg::WORD_W-1]) begin
            mag2 = {(MAG_W'(0) - MAG_W'(r_read_word))} << 1;
        end else begin
            mag2 = MAG_W'(r_read_word) << 1;
        end
        prod = PROD_W'(mag2) * PROD_W'(i2cscr_pkg::RECIP_5);
    end

    // one tick of the bus sequencer
    always_comb begin
        n_st          = r_st;
        n_byt         = r_byt;
        n_bit_index   = r_bit_index;
        n_shift_byte  = r_shift_byte;
        n_read_word   = r_read_word;
        n_chosen_port = r_chosen_port;
        done          = 1'b0;
        ok            = 1'b0;
        cur_ma        = '0;

        case (r_st)
            ST_FREE: n_st = ST_SLOW;
            ST_SLOW: begin
                n_shift_byte = {dev_addr, (r_byt == BYT_ADDR_R)};
                n_bit_index  = 4'd7;
                n_st         = ST_WLOW;
            end
            ST_WLOW: n_st = ST_WHIGH;
            ST_WHIGH: begin
                if (r_bit_index != 4'd0) begin
                    n_bit_index = r_bit_index - 4'd1;
                    n_st        = ST_WLOW;
                end else begin
                    n_st = ST_ALOW;
                end
            end
            ST_ALOW: n_st = ST_AHIGH;
            ST_AHIGH: begin
                if (in_sda) begin
                    // missing acknowledge: stop and report failure
                    n_st = ST_PA;
                end else if (r_byt == BYT_ADDR_W) begin
                    n_shift_byte = i2cscr_pkg::shunt_reg_of(r_chosen_port);
                    n_bit_index  = 4'd7;
                    n_byt        = BYT_REG;
                    n_st         = ST_WLOW;
                end else if (r_byt == BYT_REG) begin
                    n_byt = BYT_ADDR_R;
                    n_st  = ST_RSLOW;
                end else begin
                    n_read_word = '0;
                    n_bit_index = 4'd0;
                    n_byt       = BYT_DATA;
                    n_st        = ST_RLOW;
                end
            end
            ST_RSLOW: n_st = ST_FREE;
            ST_RLOW:  n_st = ST_RHIGH;
            ST_RHIGH: begin
                n_read_word = {r_read_word[i2cscr_pkg::WORD_W-2:0], in_sda};
                n_bit_index = r_bit_index + 4'd1;
                if (n_bit_index == 4'd8 || n_bit_index == 4'd0) begin
                    n_st = ST_MLOW;
                end else begin
                    n_st = ST_RLOW;
                end
            end
            ST_MLOW: n_st = ST_MHIGH;
            ST_MHIGH: begin
                n_st = (r_bit_index == 4'd0) ? ST_PA : ST_RLOW;
            end
            ST_PA: n_st = ST_PB;
            ST_PB: begin
                done = 1'b1;
                if (r_byt == BYT_DATA) begin
                    ok     = 1'b1;
                    cur_ma = prod[i2cscr_pkg::RECIP_SHR +: i2cscr_pkg::CUR_W];
                end
                n_st  = ST_IDLE;
                n_byt = BYT_ADDR_W;
            end
            default: begin
                n_st  = ST_IDLE;
                n_byt = BYT_ADDR_W;
                if (in_req) begin
                    if (in_port >= i2cscr_pkg::PORT_W'(i2cscr_pkg::PORT_COUNT)) begin
                        // port out of range: finish at once, bus untouched
                        done = 1'b1;
                    end else begin
                        n_chosen_port = in_port[i2cscr_pkg::CHAN_W-1:0];
                        n_st          = ST_FREE;
                    end
                end
            end
        endcase

        // line drive for the new phase
        tx_bit  = n_shift_byte[n_bit_index[2:0]];
        scl_low = 1'b0;
        sda_low = 1'b0;
        case (n_st)
            ST_SLOW: sda_low = 1'b1;
            ST_WLOW: begin
                scl_low = 1'b1;
                sda_low = !tx_bit;
            end
            ST_WHIGH: sda_low = !tx_bit;
            ST_ALOW, ST_RSLOW, ST_RLOW: scl_low = 1'b1;
            ST_MLOW: begin
                // ack after the first data byte, nack after the second
                scl_low = 1'b1;
                sda_low = (n_bit_index == 4'd8);
            end
            ST_MHIGH: sda_low = (n_bit_index == 4'd8);
            ST_PA: begin
                scl_low = 1'b1;
                sda_low = 1'b1;
            end
            ST_PB: sda_low = 1'b1;
            default: begin
                scl_low = 1'b0;
                sda_low = 1'b0;
            end
        endcase

        n_out_data = {5'd0, cur_ma, ok, done, (n_st != ST_IDLE), sda_low, scl_low};
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon_a_addr <= 7'd64;
            r_mon_b_addr <= 7'd65;
            r_mon_c_addr <= 7'd66;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                i2cscr_pkg::CFG_MON_A: r_mon_a_addr <= i_cfg_data;
                i2cscr_pkg::CFG_MON_B: r_mon_b_addr <= i_cfg_data;
                i2cscr_pkg::CFG_MON_C: r_mon_c_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer registers advance once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= ST_IDLE;
            r_byt         <= BYT_ADDR_W;
            r_bit_index   <= '0;
            r_shift_byte  <= '0;
            r_read_word   <= '0;
            r_chosen_port <= '0;
        end else if (in_accept) begin
            r_st          <= n_st;
            r_byt         <= n_byt;
            r_bit_index   <= n_bit_index;
            r_shift_byte  <= n_shift_byte;
            r_read_word   <= n_read_word;
            r_chosen_port <= n_chosen_port;
        end
    end

    // output register: holds one result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

[tb/i2c_shunt_current_reader_top_tb.sv]
// self-checking testbench for the shunt current reader: directed table, then random bus traffic
module i2c_shunt_current_reader_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // sequencer states of the bus master, as the tb tracks them
    typedef enum logic [3:0] {
        SQ_IDLE, SQ_FREE, SQ_START_LOW, SQ_WBIT_LOW, SQ_WBIT_HIGH, SQ_ACK_LOW, SQ_ACK_HIGH,
        SQ_RESTART_LOW, SQ_RBIT_LOW, SQ_RBIT_HIGH, SQ_MACK_LOW, SQ_MACK_HIGH,
        SQ_STOP_A, SQ_STOP_B
    } t_seq_state;

    // one output beat, packed the way m_axis_tdata[18:0] carries it
    typedef struct packed {
        logic [i2cscr_pkg::CUR_W-1:0] cur;
        logic                         ok;
        logic                         done;
        logic                         busy;
        logic                         sda;
        logic                         scl;
    } t_tick_result;

    // one row of the directed table
    typedef struct {
        bit          req;
        logic [3:0]  port;
        logic [2:0]  acks;      // bit n set: byte n acknowledged by the monitor
        logic [15:0] word;      // word the monitor returns, msb first
        bit          pin;       // last beat has a hand-typed expectation
        logic        ok;
        logic [13:0] cur;
        bit          retarget;  // rewrite the monitor address at the repeated start
        logic [6:0]  new_addr;
    } t_dir_row;

    localparam int DIR_ROWS    = 15;
    localparam int PHASE_TICKS = 130;
    localparam int HOLD_CYCLES = 300;

    // port to shunt pointer and port to address register, port 0 in the lowest slot
    localparam logic [63:0] SHUNT_PTRS = {i2cscr_pkg::SHUNT_REG_3, i2cscr_pkg::SHUNT_REG_1,
                                          i2cscr_pkg::SHUNT_REG_3, i2cscr_pkg::SHUNT_REG_2,
                                          i2cscr_pkg::SHUNT_REG_1, i2cscr_pkg::SHUNT_REG_3,
                                          i2cscr_pkg::SHUNT_REG_2, i2cscr_pkg::SHUNT_REG_1};
    localparam logic [15:0] MON_REGS   = {i2cscr_pkg::CFG_MON_C, i2cscr_pkg::CFG_MON_C,
                                          i2cscr_pkg::CFG_MON_B, i2cscr_pkg::CFG_MON_B,
                                          i2cscr_pkg::CFG_MON_B, i2cscr_pkg::CFG_MON_A,
                                          i2cscr_pkg::CFG_MON_A, i2cscr_pkg::CFG_MON_A};

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_wen;
    logic [i2cscr_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [i2cscr_pkg::ADDR_W-1:0]      i_cfg_data;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    // start_request[0], port[4:1], sda_sample[5], pad[7:6]
    logic [i2cscr_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // scl_drive_low[0], sda_drive_low[1], busy_res[2], done_res[3], ok[4],
    // current_ma[18:5], pad[23:19]
    logic [i2cscr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    i2c_shunt_current_reader_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // shadow of the sequencer and the address registers
    t_seq_state  sq_state;
    logic [1:0]  sq_byte;     // 0 address write, 1 register byte, 2 address read, 3 data
    logic [3:0]  sq_bit;
    logic [7:0]  sq_shift;
    logic [15:0] sq_word;
    logic [2:0]  sq_port;
    logic [6:0]  mon_addr [3];

    // expected output beats, oldest first
    t_tick_result expected_ticks [$];

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;

    int n_errors, n_ticks, n_work_ticks, n_meas, n_read_ok, n_read_fail;
    int n_cfg_writes, n_in_stalls;

    t_dir_row dir_rows [DIR_ROWS];

    // one bus-delay tick of the master: next state, line drive and result
    task automatic advance_sequencer(input logic req, input logic [3:0] port, input logic sda,
                                     output t_tick_result r);
        logic        bit_now;
        logic [16:0] mag;
        logic [1:0]  line;
        r = '0;
        case (sq_state)
            SQ_FREE: sq_state = SQ_START_LOW;
            SQ_START_LOW: begin
                // address byte is loaded here, so a new address counts from the next load
                sq_shift = {mon_addr[MON_REGS[sq_port*2 +: 2]], sq_byte == 2'd2};
                sq_bit   = 4'd7;
                sq_state = SQ_WBIT_LOW;
            end
            SQ_WBIT_LOW: sq_state = SQ_WBIT_HIGH;
            SQ_WBIT_HIGH: begin
                if (sq_bit > 0) begin
                    sq_bit   = sq_bit - 4'd1;
                    sq_state = SQ_WBIT_LOW;
                end else begin
                    sq_state = SQ_ACK_LOW;
                end
            end
            SQ_ACK_LOW: sq_state = SQ_ACK_HIGH;
            SQ_ACK_HIGH: begin
                if (sda) begin
                    // nack: straight to stop
                    sq_state = SQ_STOP_A;
                end else if (sq_byte == 2'd0) begin
                    sq_shift = SHUNT_PTRS[sq_port*8 +: 8];
                    sq_bit   = 4'd7;
                    sq_byte  = 2'd1;
                    sq_state = SQ_WBIT_LOW;
                end else if (sq_byte == 2'd1) begin
                    sq_byte  = 2'd2;
                    sq_state = SQ_RESTART_LOW;
                end else begin
                    sq_word  = '0;
                    sq_bit   = 4'd0;
                    sq_byte  = 2'd3;
                    sq_state = SQ_RBIT_LOW;
                end
            end
            SQ_RESTART_LOW: sq_state = SQ_FREE;
            SQ_RBIT_LOW: sq_state = SQ_RBIT_HIGH;
            SQ_RBIT_HIGH: begin
                sq_word  = {sq_word[14:0], sda};
                sq_bit   = sq_bit + 4'd1;
                sq_state = (sq_bit == 4'd8 || sq_bit == 4'd0) ? SQ_MACK_LOW : SQ_RBIT_LOW;
            end
            SQ_MACK_LOW: sq_state = SQ_MACK_HIGH;
            SQ_MACK_HIGH: sq_state = (sq_bit == 4'd0) ? SQ_STOP_A : SQ_RBIT_LOW;
            SQ_STOP_A: sq_state = SQ_STOP_B;
            SQ_STOP_B: begin
                r.done = 1'b1;
                if (sq_byte == 2'd3) begin
                    // magnitude of the signed word, 0x8000 gives 32768
                    mag   = sq_word[15] ? 17'h10000 - {1'b0, sq_word} : {1'b0, sq_word};
                    r.ok  = 1'b1;
                    r.cur = i2cscr_pkg::CUR_W'((int'(mag) * 2) / 5);
                end
                sq_state = SQ_IDLE;
                sq_byte  = 2'd0;
            end
            default: begin
                sq_state = SQ_IDLE;
                sq_byte  = 2'd0;
                if (req) begin
                    if (port >= i2cscr_pkg::PORT_COUNT) begin
                        // bad port ends at once, bus untouched
                        r.done = 1'b1;
                    end else begin
                        sq_port  = port[2:0];
                        sq_state = SQ_FREE;
                    end
                end
            end
        endcase

        // line drive of the new state: bit 0 scl low, bit 1 sda low
        bit_now = sq_shift[sq_bit[2:0]];
        case (sq_state)
            SQ_START_LOW:                            line = 2'b10;
            SQ_WBIT_LOW:                             line = {~bit_now, 1'b1};
            SQ_WBIT_HIGH:                            line = {~bit_now, 1'b0};
            SQ_ACK_LOW, SQ_RESTART_LOW, SQ_RBIT_LOW: line = 2'b01;
            SQ_MACK_LOW:                             line = {sq_bit == 4'd8, 1'b1};
            SQ_MACK_HIGH:                            line = {sq_bit == 4'd8, 1'b0};
            SQ_STOP_A:                               line = 2'b11;
            SQ_STOP_B:                               line = 2'b10;
            default:                                 line = 2'b00;
        endcase
        r.scl  = line[0];
        r.sda  = line[1];
        r.busy = (sq_state != SQ_IDLE);
    endtask

    // offer one tick beat, wait for it to be taken, queue what it must produce
    task automatic send_tick(input logic req, input logic [3:0] port, input logic sda,
                             input bit pin, input t_tick_result pinned,
                             output t_tick_result r);
        bit was_busy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, sda, port, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        was_busy = (sq_state != SQ_IDLE);
        advance_sequencer(req, port, sda, r);
        n_ticks++;
        if (req || was_busy) n_work_ticks++;
        if (r.done) begin
            if (r.ok) n_read_ok++;
            else n_read_fail++;
        end
        // hand-typed expectation replaces the last beat of a directed row
        if (pin && !r.busy) r = pinned;
        expected_ticks.push_back(r);
        @(negedge i_clk);
    endtask

    // stop offering and let every queued beat come out
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_ticks.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        if (expected_ticks.size() != 0) begin
            n_errors++;
            $display("%0t ns: %0d result beats never arrived", $time, expected_ticks.size());
            expected_ticks.delete();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_monitor_addr(input logic [i2cscr_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [6:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        @(negedge i_clk);
        mon_addr[idx] = val;
        n_cfg_writes++;
    endtask

    // one measurement: request, then play the monitor until the master is idle again
    task automatic measure(input logic [3:0] port, input logic [2:0] acks,
                           input logic [15:0] word, input bit noise, input bit pin,
                           input t_tick_result pinned, input bit retarget,
                           input logic [6:0] new_addr);
        logic         sda;
        t_tick_result r;
        n_meas++;
        send_tick(1'b1, port, 1'($urandom_range(1)), pin, pinned, r);
        while (r.busy) begin
            if (retarget && sq_state == SQ_RESTART_LOW) begin
                // address change between the two address loads of one transfer
                drain();
                write_monitor_addr(MON_REGS[sq_port*2 +: 2], new_addr);
                retarget = 1'b0;
            end
            sda = 1'($urandom_range(1));
            if (!noise) begin
                if (sq_state == SQ_ACK_HIGH) sda = ~acks[sq_byte];
                else if (sq_state == SQ_RBIT_HIGH) sda = word[4'd15 - sq_bit];
            end
            // requests during a transfer, the done beat included, must be ignored
            send_tick(1'($urandom_range(3) == 0), 4'($urandom_range(15)), sda, pin, pinned, r);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result side: compare every taken beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_tick_result want, got;
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) n_in_stalls++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[18:0];
            if (expected_ticks.size() == 0) begin
                n_errors++;
                $display("%0t ns: result beat with nothing expected, actual %h",
                         $time, m_axis_tdata);
            end else begin
                want = expected_ticks.pop_front();
                check_field("scl_drive_low", want.scl, got.scl);
                check_field("sda_drive_low", want.sda, got.sda);
                check_field("busy_res", want.busy, got.busy);
                check_field("done_res", want.done, got.done);
                check_field("ok", want.ok, got.ok);
                check_field("current_ma", want.cur, got.cur);
            end
        end
    end

    // result side ready: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // run limit, far above the slowest correct run
    initial begin
        #5_000_000;
        $display("timeout: run did not complete");
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int           i, ph, k, start;
        t_dir_row     row;
        t_tick_result pinned, r;
        logic [6:0]   addr_set [3];
        logic [3:0]   port;
        logic [15:0]  word;
        logic [2:0]   acks;

        i_rst_n       = 1'b0;
        i_cfg_wen     = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_req      = 1'b0;
        send_idle_pct  = 29;
        recv_stall_pct = 29;

        // shadow state after reset
        sq_state    = SQ_IDLE;
        sq_byte     = '0;
        sq_bit      = '0;
        sq_shift    = '0;
        sq_word     = '0;
        sq_port     = '0;
        mon_addr[0] = 7'd64;
        mon_addr[1] = 7'd65;
        mon_addr[2] = 7'd66;

        // req, port, acks, word, pin, ok, cur, retarget, new_addr
        dir_rows[0]  = '{1'b0, 4'd0,  3'b111, 16'h0000, 1'b1, 1'b0, 14'd0,     1'b0, 7'd0};
        dir_rows[1]  = '{1'b1, 4'd8,  3'b111, 16'h0000, 1'b1, 1'b0, 14'd0,     1'b0, 7'd0};
        dir_rows[2]  = '{1'b1, 4'd15, 3'b111, 16'h0000, 1'b1, 1'b0, 14'd0,     1'b0, 7'd0};
        dir_rows[3]  = '{1'b1, 4'd0,  3'b111, 16'h8000, 1'b1, 1'b1, 14'd13107, 1'b0, 7'd0};
        dir_rows[4]  = '{1'b1, 4'd1,  3'b111, 16'h7fff, 1'b1, 1'b1, 14'd13106, 1'b0, 7'd0};
        dir_rows[5]  = '{1'b1, 4'd2,  3'b111, 16'h0000, 1'b1, 1'b1, 14'd0,     1'b0, 7'd0};
        dir_rows[6]  = '{1'b1, 4'd3,  3'b111, 16'hffff, 1'b1, 1'b1, 14'd0,     1'b0, 7'd0};
        dir_rows[7]  = '{1'b1, 4'd4,  3'b111, 16'h0005, 1'b1, 1'b1, 14'd2,     1'b0, 7'd0};
        dir_rows[8]  = '{1'b1, 4'd5,  3'b111, 16'hfffb, 1'b1, 1'b1, 14'd2,     1'b0, 7'd0};
        dir_rows[9]  = '{1'b1, 4'd6,  3'b110, 16'h1234, 1'b1, 1'b0, 14'd0,     1'b0, 7'd0};
        dir_rows[10] = '{1'b1, 4'd7,  3'b101, 16'h1234, 1'b1, 1'b0, 14'd0,     1'b0, 7'd0};
        dir_rows[11] = '{1'b1, 4'd0,  3'b011, 16'h1234, 1'b1, 1'b0, 14'd0,     1'b0, 7'd0};
        dir_rows[12] = '{1'b1, 4'd7,  3'b111, 16'h1234, 1'b0, 1'b0, 14'd0,     1'b0, 7'd0};
        dir_rows[13] = '{1'b1, 4'd3,  3'b111, 16'ha5c3, 1'b0, 1'b0, 14'd0,     1'b1, 7'h7f};
        dir_rows[14] = '{1'b1, 4'd6,  3'b111, 16'h0001, 1'b1, 1'b1, 14'd0,     1'b0, 7'd0};

        // hold synchronous reset, then release it
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part: idle tick, bad ports, word extremes, every port, each nack point,
        // address change at the repeated start
        for (i = 0; i < DIR_ROWS; i++) begin
            row    = dir_rows[i];
            pinned = '{cur: row.cur, ok: row.ok, done: row.req,
                       busy: 1'b0, sda: 1'b0, scl: 1'b0};
            if (row.req)
                measure(row.port, row.acks, row.word, 1'b0, row.pin, pinned,
                        row.retarget, row.new_addr);
            else
                send_tick(1'b0, row.port, 1'b0, row.pin, pinned, r);
        end
        drain();

        // random part in four idling phases, new monitor addresses before each
        for (ph = 0; ph < 4; ph++) begin
            for (k = 0; k < 3; k++) addr_set[k] = 7'($urandom_range(127));
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    addr_set[0]    = 7'd0;
                    addr_set[1]    = 7'd127;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                    addr_set[0]    = 7'd127;
                    addr_set[1]    = 7'd0;
                    addr_set[2]    = 7'd127;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                    addr_set[2]    = 7'd0;
                end
                default: begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            write_monitor_addr(i2cscr_pkg::CFG_MON_A, addr_set[0]);
            write_monitor_addr(i2cscr_pkg::CFG_MON_B, addr_set[1]);
            write_monitor_addr(i2cscr_pkg::CFG_MON_C, addr_set[2]);

            // long receiver hold-off while the sender keeps offering
            if (ph == 0) hold_req = 1'b1;

            start = n_work_ticks;
            while (n_work_ticks - start < PHASE_TICKS) begin
                repeat ($urandom_range(2))
                    send_tick(1'b0, 4'($urandom_range(15)), 1'($urandom_range(1)),
                              1'b0, '0, r);
                port = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8))
                                                : 4'($urandom_range(7));
                case ($urandom_range(7))
                    0:       word = 16'h8000;
                    1:       word = 16'h7fff;
                    2:       word = 16'h0000;
                    3:       word = 16'hffff;
                    default: word = 16'($urandom);
                endcase
                // mostly fully acknowledged transfers, some broken ones
                acks = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'b111;
                measure(port, acks, word, $urandom_range(19) == 0, 1'b0, '0, 1'b0, 7'd0);
            end
            drain();
        end

        repeat (8) @(negedge i_clk);
        $display("covered %0d ticks in %0d measurements: %0d read ok, %0d nack or bad port",
                 n_ticks, n_meas, n_read_ok, n_read_fail);
        $display("%0d address writes, input held off by the block for %0d cycles",
                 n_cfg_writes, n_in_stalls);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/i2cscr_pkg.sv
design/i2c_shunt_current_reader_top.sv
tb/i2c_shunt_current_reader_top_tb.sv
